// File: hdl/rthsl_pkg.sv
package rthsl_pkg;

  localparam int unsigned ChannelBitsDefault = 8;

  // quotient bit per cell, numerator/denominator widths follow from channel bits
  function automatic int unsigned num_bits(input int unsigned cb);
    return 2 * cb + 5;
  endfunction

endpackage

// File: hdl/rthsl_stream_if.sv
interface rthsl_stream_if #(
  parameter int unsigned W = 8
);
  logic         valid;
  logic         ready;
  logic [W-1:0] red;
  logic [W-1:0] green;
  logic [W-1:0] blue;
  logic         end_of_run;
  logic [W-1:0] hue;
  logic [W-1:0] saturation;
  logic [W-1:0] lightness;
  logic         end_of_run_out;

  modport source (
    output valid, red, green, blue, end_of_run, hue, saturation, lightness, end_of_run_out,
    input  ready
  );
  modport sink (
    input  valid, red, green, blue, end_of_run, hue, saturation, lightness, end_of_run_out,
    output ready
  );
endinterface

// File: hdl/rthsl_front.sv
module rthsl_front
  import rthsl_pkg::*;
#(
  parameter int unsigned CW = ChannelBitsDefault,
  parameter int unsigned NW = 2 * CW + 5
) (
  input  logic [CW-1:0] red_i,
  input  logic [CW-1:0] green_i,
  input  logic [CW-1:0] blue_i,
  output logic [NW-1:0] hue_num_o,
  output logic [NW-1:0] hue_den_o,
  output logic [NW-1:0] sat_num_o,
  output logic [NW-1:0] sat_den_o,
  output logic [CW-1:0] light_o,
  output logic          gray_o
);
  localparam logic [CW:0] MaxV = {1'b0, {CW{1'b1}}};

  logic [CW-1:0] hi, lo, gb_max, br_max;
  logic [CW:0]   c, sum, den, num;
  logic [CW+3:0] c6, hnum;

  always_comb begin
    hi = red_i;
    lo = red_i;
    if (green_i > hi) hi = green_i;
    if (blue_i > hi) hi = blue_i;
    if (green_i < lo) lo = green_i;
    if (blue_i < lo) lo = blue_i;
    c   = {1'b0, hi} - {1'b0, lo};
    sum = {1'b0, hi} + {1'b0, lo};
    gb_max = (green_i > blue_i) ? green_i : blue_i;
    br_max = (blue_i > red_i) ? blue_i : red_i;
    c6 = {3'b0, c} * (CW + 4)'(6);
    num = '0;
    if (red_i >= gb_max) begin
      if (green_i >= blue_i) hnum = {3'b0, {1'b0, green_i} - {1'b0, blue_i}};
      else hnum = c6 - {3'b0, {1'b0, blue_i} - {1'b0, green_i}};
    end else if (green_i >= br_max) begin
      hnum = {2'b0, c, 1'b0} + {4'b0, blue_i} - {4'b0, red_i};
    end else begin
      hnum = {1'b0, c, 2'b0} + {4'b0, red_i} - {4'b0, green_i};
    end
    den = (sum >= MaxV) ? ((MaxV << 1) - sum) : sum;
    num = c;
    // round(maxv*n/d) = floor((2*maxv*n + d) / (2*d))
    hue_num_o = NW'({hnum, 1'b0}) * NW'(MaxV) + NW'(c6);
    hue_den_o = NW'({c6, 1'b0});
    sat_num_o = NW'({num, 1'b0}) * NW'(MaxV) + NW'(den);
    sat_den_o = NW'({den, 1'b0});
    light_o   = CW'((sum + 1'b1) >> 1);
    gray_o    = (c == '0);
  end
endmodule

// File: hdl/rthsl_div_cell.sv
module rthsl_div_cell
  import rthsl_pkg::*;
#(
  parameter int unsigned CW  = ChannelBitsDefault,
  parameter int unsigned NW  = 2 * CW + 5,
  parameter int unsigned BIT = 0
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] h_rem_i,
  input  logic [NW-1:0] h_den_i,
  input  logic [CW-1:0] h_q_i,
  input  logic [NW-1:0] s_rem_i,
  input  logic [NW-1:0] s_den_i,
  input  logic [CW-1:0] s_q_i,
  input  logic [CW-1:0] light_i,
  input  logic          gray_i,
  input  logic          eor_i,
  output logic [NW-1:0] h_rem_o,
  output logic [NW-1:0] h_den_o,
  output logic [CW-1:0] h_q_o,
  output logic [NW-1:0] s_rem_o,
  output logic [NW-1:0] s_den_o,
  output logic [CW-1:0] s_q_o,
  output logic [CW-1:0] light_o,
  output logic          gray_o,
  output logic          eor_o
);
  // one restoring quotient bit for hue and for saturation
  logic [NW+CW-1:0] h_sh, s_sh;
  logic             h_ge, s_ge;
  logic [NW-1:0]    h_rem_d, s_rem_d;
  logic [CW-1:0]    h_q_d, s_q_d;

  always_comb begin
    h_sh = {{CW{1'b0}}, h_den_i} << BIT;
    s_sh = {{CW{1'b0}}, s_den_i} << BIT;
    h_ge = ({{CW{1'b0}}, h_rem_i} >= h_sh);
    s_ge = ({{CW{1'b0}}, s_rem_i} >= s_sh);
    h_rem_d = h_ge ? h_rem_i - NW'(h_sh) : h_rem_i;
    s_rem_d = s_ge ? s_rem_i - NW'(s_sh) : s_rem_i;
    h_q_d = h_q_i;
    s_q_d = s_q_i;
    h_q_d[BIT] = h_ge;
    s_q_d[BIT] = s_ge;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      h_rem_o <= h_rem_d;
      h_den_o <= h_den_i;
      h_q_o   <= h_q_d;
      s_rem_o <= s_rem_d;
      s_den_o <= s_den_i;
      s_q_o   <= s_q_d;
      light_o <= light_i;
      gray_o  <= gray_i;
      eor_o   <= eor_i;
    end
  end
endmodule

// File: hdl/rgb_to_hsl_pixel_convert.sv
// path: each pixel is registered in every divider cell from input request to output valid
// throughput: one pixel per cycle unless stalled, set by the chain of restoring
// divider cells (one quotient bit per cell, hue and saturation side by side)
// the whole chain stalls when the output is held and the last stage is full
// reset clears the stage valid bits only
module rgb_to_hsl_pixel_convert
  import rthsl_pkg::*;
#(
  parameter int unsigned CHANNEL_BITS = ChannelBitsDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  rthsl_stream_if.sink   in_i,
  rthsl_stream_if.source out_o
);
  localparam int unsigned CW = CHANNEL_BITS;
  localparam int unsigned NW = num_bits(CW);
  localparam int unsigned NS = CW + 1;

  logic [NW-1:0] h_rem [NS], h_den [NS], s_rem [NS], s_den [NS];
  logic [CW-1:0] h_q [NS], s_q [NS], light [NS];
  logic          gray [NS], eor [NS];
  logic [CW-1:0] vld_q, vld_d;
  logic          adv;

  assign adv = !vld_q[CW-1] || out_o.ready;
  assign in_i.ready = adv;
  assign vld_d = {vld_q[CW-2:0], in_i.valid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (adv) vld_q <= vld_d;
  end

  rthsl_front #(.CW(CW), .NW(NW)) u_front (
    .red_i(in_i.red), .green_i(in_i.green), .blue_i(in_i.blue),
    .hue_num_o(h_rem[0]), .hue_den_o(h_den[0]),
    .sat_num_o(s_rem[0]), .sat_den_o(s_den[0]),
    .light_o(light[0]), .gray_o(gray[0])
  );
  assign h_q[0] = '0;
  assign s_q[0] = '0;
  assign eor[0] = in_i.end_of_run;

  for (genvar i = 0; i < CW; i++) begin : g_cell
    rthsl_div_cell #(.CW(CW), .NW(NW), .BIT(CW - 1 - i)) u_cell (
      .clk_i, .en_i(adv),
      .h_rem_i(h_rem[i]), .h_den_i(h_den[i]), .h_q_i(h_q[i]),
      .s_rem_i(s_rem[i]), .s_den_i(s_den[i]), .s_q_i(s_q[i]),
      .light_i(light[i]), .gray_i(gray[i]), .eor_i(eor[i]),
      .h_rem_o(h_rem[i+1]), .h_den_o(h_den[i+1]), .h_q_o(h_q[i+1]),
      .s_rem_o(s_rem[i+1]), .s_den_o(s_den[i+1]), .s_q_o(s_q[i+1]),
      .light_o(light[i+1]), .gray_o(gray[i+1]), .eor_o(eor[i+1])
    );
  end

  // quotient never exceeds maxv, so cw bits are exact
  assign out_o.valid          = vld_q[CW-1];
  assign out_o.hue            = gray[NS-1] ? '0 : h_q[NS-1];
  assign out_o.saturation     = gray[NS-1] ? '0 : s_q[NS-1];
  assign out_o.lightness      = light[NS-1];
  assign out_o.end_of_run_out = eor[NS-1];
  assign out_o.red            = '0;
  assign out_o.green          = '0;
  assign out_o.blue           = '0;
  assign out_o.end_of_run     = 1'b0;
endmodule
